// ===== rtl/square_matrix_add_sub_mul_top_defines.svh =====
// Assertion macros used by the matrix unit's checker file.
`ifndef SQUARE_MATRIX_ADD_SUB_MUL_TOP_DEFINES_SVH
`define SQUARE_MATRIX_ADD_SUB_MUL_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define SMAS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matrix unit check failed");

// Next-cycle implication, disabled while reset is high
`define SMAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matrix unit check failed");

`endif

// ===== rtl/smas_pkg.sv =====
// Package: types and constants of the square matrix add, subtract and multiply unit.
`default_nettype none
package smas_pkg;

   localparam int MAX_DIM = 64;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int DATA_W  = 32;
   localparam int SIZE_W  = 7;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_SUM  = 2'd1,
      CMD_DIFF = 2'd2,
      CMD_PROD = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADDSUB,
      ST_PROD,
      ST_FIN
   } state_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic [IDX_W-1:0]          row_index;
      logic [IDX_W-1:0]          col_index;
      logic signed [DATA_W-1:0]  a_value;
      logic signed [DATA_W-1:0]  b_value;
   } req_word_type;

   typedef struct packed {
      logic [IDX_W-1:0]          out_row;
      logic [IDX_W-1:0]          out_col;
      logic signed [DATA_W-1:0]  element_value;
      logic                      bad_index;
   } rsp_word_type;

endpackage
`default_nettype wire

// ===== rtl/smas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module smas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, register the read word for the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/square_matrix_add_sub_mul_top.sv =====
// An in-range load writes both matrices at its accept edge and gives no word. A sum or
// difference word passes through the RAM read register and the accumulator into the output
// register, an out-of-range read goes straight to the output register; a product word walks k
// through the RAM read, product and accumulator registers, one multiply-accumulate per cycle over
// k. Loads: one per cycle while idle; a read holds req_ready low until its word is in the output register.
// Reset: synchronous; clears control and sets matrix size to 1, matrix contents stay unwritten.
`default_nettype none
module square_matrix_add_sub_mul_top (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire smas_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output smas_pkg::rsp_word_type     rsp_word,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [smas_pkg::SIZE_W-1:0] csr_wdata
);
   import smas_pkg::*;

   state_type              state_ff, state_in;
   logic [SIZE_W-1:0]      size_ff;
   logic [SIZE_W-1:0]      n_ff, n_in;
   logic [SIZE_W-1:0]      k_ff, k_in;
   cmd_type                cmd_ff, cmd_in;
   logic [IDX_W-1:0]       row_ff, row_in;
   logic [IDX_W-1:0]       col_ff, col_in;
   logic                   bad_ff, bad_in;
   logic [DATA_W-1:0]      acc_ff, acc_in;
   logic [DATA_W-1:0]      prod_ff, prod_in;
   logic                   rd_v_ff, rd_v_in;
   logic                   prod_v_ff, prod_v_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic [SIZE_W-1:0]      n_eff;
   logic                   in_range;
   logic                   req_fire;
   logic                   issue_en;
   logic                   rsp_free;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0]      rd_a, rd_b;
   logic [DATA_W-1:0]      full_prod;

   // configuration register, to be written only while idle; the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(1);
      end else if (csr_valid) begin
         size_ff <= csr_wdata;
      end
   end

   // clamp size and check the request's indices
   assign n_eff    = (size_ff > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_ff;
   assign in_range = ({1'b0, req_word.row_index} < n_eff) &&
                     ({1'b0, req_word.col_index} < n_eff);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign issue_en  = (state_ff == ST_PROD) && (k_ff < n_ff);

   // memory ports: load writes both, reads take row/col or walk k
   assign wr_en   = req_fire && (req_word.cmd == CMD_LOAD) && in_range;
   assign wr_addr = {req_word.row_index, req_word.col_index};
   assign rd_en   = (req_fire && (req_word.cmd != CMD_LOAD) && in_range) || issue_en;

   always_comb begin
      if (state_ff == ST_PROD) begin
         rd_addr_a = {row_ff, k_ff[IDX_W-1:0]};
         rd_addr_b = {k_ff[IDX_W-1:0], col_ff};
      end else begin
         rd_addr_a = {req_word.row_index, req_word.col_index};
         rd_addr_b = {req_word.row_index, req_word.col_index};
      end
   end

   smas_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_word.a_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   smas_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_word.b_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   // keep the low word of the product, the sum wraps at 32 bits
   assign full_prod = rd_a * rd_b;

   // next state, accumulate pipeline and output register
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      bad_in       = bad_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rd_v_in      = issue_en;
      prod_v_in    = rd_v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;

      // multiply stage and accumulate stage
      if (rd_v_ff) begin
         prod_in = full_prod;
      end
      if (prod_v_ff) begin
         acc_in = acc_ff + prod_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_word.cmd != CMD_LOAD)) begin
               cmd_in = req_word.cmd;
               row_in = req_word.row_index;
               col_in = req_word.col_index;
               bad_in = !in_range;
               n_in   = n_eff;
               k_in   = '0;
               acc_in = '0;
               if (!in_range) begin
                  state_in = ST_FIN;
               end else if (req_word.cmd == CMD_PROD) begin
                  state_in = ST_PROD;
               end else begin
                  state_in = ST_ADDSUB;
               end
            end
         end
         ST_ADDSUB: begin
            acc_in   = (cmd_ff == CMD_SUM) ? (rd_a + rd_b) : (rd_a - rd_b);
            state_in = ST_FIN;
         end
         ST_PROD: begin
            if (issue_en) begin
               k_in = k_ff + SIZE_W'(1);
            end else if (!rd_v_ff && !prod_v_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.out_row       = row_ff;
               rsp_word_in.out_col       = col_ff;
               rsp_word_in.element_value = $signed(acc_ff);
               rsp_word_in.bad_index     = bad_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold control under reset, payload free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= rd_v_in;
         prod_v_ff    <= prod_v_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
      n_ff        <= n_in;
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      bad_ff      <= bad_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

// ===== rtl/smas_chk.sv =====
// Port-level checker for the matrix unit, bound to the top level.
`default_nettype none
`include "square_matrix_add_sub_mul_top_defines.svh"
module smas_chk (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire smas_pkg::req_word_type req_word,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire smas_pkg::rsp_word_type rsp_word
);
   import smas_pkg::*;

   // hold a stalled result word
   `SMAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SMAS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_word))

   // out-of-range reads return zero
   `SMAS_ASSERT_NOW(a_bad_zero, clock, reset, rsp_valid && rsp_word.bad_index, rsp_word.element_value == 0)

   // loads keep the unit open, reads close it
   `SMAS_ASSERT_NEXT(a_load_ready, clock, reset, req_valid && req_ready && (req_word.cmd == CMD_LOAD), req_ready)
   `SMAS_ASSERT_NEXT(a_read_busy, clock, reset, req_valid && req_ready && (req_word.cmd != CMD_LOAD), !req_ready)

endmodule

bind square_matrix_add_sub_mul_top smas_chk u_smas_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
`default_nettype wire

// ===== sim/square_matrix_add_sub_mul_top_tb.sv =====
// Self-checking testbench for the square matrix add, subtract and multiply unit.
`timescale 1ns / 1ps
module square_matrix_add_sub_mul_top_tb;
   import smas_pkg::*;

   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BUDGET   = 28;
   localparam int MAX_STALL      = 16;
   localparam int MAX_REPORTS    = 200;

   typedef enum bit {ROW_SIZE, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      logic [6:0]    size_val;
      req_word_type  word;
      bit            typed;
      rsp_word_type  result;
   } script_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [6:0]   csr_wdata = 7'd1;

   // Shadow copy of both matrices and which cells hold a loaded value
   bit [DATA_W-1:0] mat_a [0:DEPTH-1];
   bit [DATA_W-1:0] mat_b [0:DEPTH-1];
   bit              loaded [0:DEPTH-1];
   logic [6:0]      cur_size = 7'd1;

   rsp_word_type    pending_elements [$];
   script_row_type  script_rows [$];
   int              mismatch_count = 0;
   int              items_sent = 0;
   int              idle_cycles = 0;
   int              stall_left = 0;
   bit              req_burst = 1'b0;
   bit              rsp_burst = 1'b0;
   bit              wide_prod_done = 1'b0;

   square_matrix_add_sub_mul_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int eff_size();
      return (cur_size > MAX_DIM) ? MAX_DIM : int'(cur_size);
   endfunction

   function automatic int cell_at(input int r, input int c);
      return r * MAX_DIM + c;
   endfunction

   // Apply one word to the shadow matrices; return 1 with the element it yields
   function automatic bit compute_element(input req_word_type w, output rsp_word_type res);
      int              n;
      int              r;
      int              c;
      int              k;
      bit              in_rng;
      logic [DATA_W-1:0] acc;
      n      = eff_size();
      r      = w.row_index;
      c      = w.col_index;
      in_rng = (r < n) && (c < n);
      res    = '0;
      acc    = '0;
      if (w.cmd == CMD_LOAD) begin
         if (in_rng) begin
            mat_a[cell_at(r, c)]  = w.a_value;
            mat_b[cell_at(r, c)]  = w.b_value;
            loaded[cell_at(r, c)] = 1'b1;
         end
         return 1'b0;
      end
      if (in_rng) begin
         case (w.cmd)
            CMD_SUM: begin
               acc = mat_a[cell_at(r, c)] + mat_b[cell_at(r, c)];
            end
            CMD_DIFF: begin
               acc = mat_a[cell_at(r, c)] - mat_b[cell_at(r, c)];
            end
            default: begin
               for (k = 0; k < n; k++)
                  acc = acc + mat_a[cell_at(r, k)] * mat_b[cell_at(k, c)];
            end
         endcase
      end
      res.out_row       = w.row_index;
      res.out_col       = w.col_index;
      res.element_value = acc;
      res.bad_index     = !in_rng;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch @%0t: %s", $time, msg);
   endtask

   // Compare one returned word with the oldest pending element
   task automatic check_element(input rsp_word_type got);
      rsp_word_type want;
      if (pending_elements.size() == 0) begin
         report_mismatch($sformatf("unexpected word row %0d col %0d value %h",
                                   got.out_row, got.out_col, got.element_value));
         return;
      end
      want = pending_elements.pop_front();
      if (got.out_row !== want.out_row)
         report_mismatch($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
      if (got.out_col !== want.out_col)
         report_mismatch($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
      if (got.element_value !== want.element_value)
         report_mismatch($sformatf("element_value %h, want %h at (%0d,%0d)",
                                   got.element_value, want.element_value,
                                   want.out_row, want.out_col));
      if (got.bad_index !== want.bad_index)
         report_mismatch($sformatf("bad_index %b, want %b at (%0d,%0d)",
                                   got.bad_index, want.bad_index,
                                   want.out_row, want.out_col));
   endtask

   // Receive side: accept a word, then hold ready low for a random stall
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         check_element(rsp_word);
         if ($urandom_range(0, 31) == 0)
            rsp_burst = ~rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, MAX_STALL);
         stall_left <= stall;
         rsp_ready  <= (stall == 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_ready  <= 1'b1;
      end
   end

   // Watchdog: count cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Drive one request word after a random gap; predict at accept
   task automatic send_req(input req_word_type w, input bit typed, input rsp_word_type typed_res);
      int           gap;
      rsp_word_type res;
      gap = req_burst ? 0 : $urandom_range(0, MAX_STALL);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (compute_element(w, res))
         pending_elements.push_back(typed ? typed_res : res);
   endtask

   // Drop valid and hold until every pending element has come back
   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_elements.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_size(input logic [6:0] v);
      wait_idle(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_size = v;
   endtask

   task automatic load_cell(input int r, input int c);
      req_word_type w;
      w.cmd       = CMD_LOAD;
      w.row_index = IDX_W'(r);
      w.col_index = IDX_W'(c);
      w.a_value   = $urandom;
      w.b_value   = $urandom;
      send_req(w, 1'b0, '0);
   endtask

   // Load every cell an in-range read will touch that holds no value yet
   task automatic load_missing(input req_word_type w);
      int n;
      int r;
      int c;
      int k;
      n = eff_size();
      r = w.row_index;
      c = w.col_index;
      if (w.cmd != CMD_PROD) begin
         if (!loaded[cell_at(r, c)])
            load_cell(r, c);
      end else begin
         for (k = 0; k < n; k++) begin
            if (!loaded[cell_at(r, k)])
               load_cell(r, k);
            if (!loaded[cell_at(k, c)])
               load_cell(k, c);
         end
      end
   endtask

   task automatic add_size(input logic [6:0] v);
      script_row_type row;
      row          = '{kind: ROW_SIZE, default: '0};
      row.size_val = v;
      script_rows.push_back(row);
   endtask

   task automatic add_item(input cmd_type cmd, input logic [5:0] r, input logic [5:0] c,
                           input logic [31:0] a, input logic [31:0] b);
      script_row_type row;
      row                = '{kind: ROW_ITEM, default: '0};
      row.word.cmd       = cmd;
      row.word.row_index = r;
      row.word.col_index = c;
      row.word.a_value   = a;
      row.word.b_value   = b;
      script_rows.push_back(row);
   endtask

   // Read with an element value known up front; a and b carry junk
   task automatic add_known(input cmd_type cmd, input logic [5:0] r, input logic [5:0] c,
                            input logic [31:0] value, input logic bad);
      add_item(cmd, r, c, $urandom, $urandom);
      script_rows[$].typed                = 1'b1;
      script_rows[$].result.out_row       = r;
      script_rows[$].result.out_col       = c;
      script_rows[$].result.element_value = value;
      script_rows[$].result.bad_index     = bad;
   endtask

   task automatic build_script();
      // size 1 straight out of reset
      add_known(CMD_SUM,  6'd0,  6'd1,  32'h0, 1'b1);
      add_known(CMD_PROD, 6'd63, 6'd63, 32'h0, 1'b1);
      add_item(CMD_LOAD, 6'd0, 6'd0, 32'h7fffffff, 32'h7fffffff);
      add_known(CMD_SUM,  6'd0, 6'd0, 32'hfffffffe, 1'b0);
      add_known(CMD_DIFF, 6'd0, 6'd0, 32'h0, 1'b0);
      add_known(CMD_PROD, 6'd0, 6'd0, 32'h1, 1'b0);
      add_item(CMD_LOAD, 6'd0, 6'd0, 32'h80000000, 32'h7fffffff);
      add_known(CMD_SUM,  6'd0, 6'd0, 32'hffffffff, 1'b0);
      add_known(CMD_DIFF, 6'd0, 6'd0, 32'h1, 1'b0);
      add_known(CMD_PROD, 6'd0, 6'd0, 32'h80000000, 1'b0);
      add_item(CMD_LOAD, 6'd1, 6'd0, 32'hffffffff, 32'hffffffff);
      // size zero: nothing is in range, loads are dropped
      add_size(7'd0);
      add_known(CMD_SUM, 6'd0, 6'd0, 32'h0, 1'b1);
      add_item(CMD_LOAD, 6'd0, 6'd0, 32'h5, 32'h5);
      add_known(CMD_PROD, 6'd0, 6'd0, 32'h0, 1'b1);
      // size above the maximum clamps to full dimension
      add_size(7'd127);
      add_item(CMD_LOAD, 6'd63, 6'd63, 32'hffffffff, 32'hffffffff);
      add_known(CMD_SUM,  6'd63, 6'd63, 32'hfffffffe, 1'b0);
      add_known(CMD_DIFF, 6'd0,  6'd0,  32'h1, 1'b0);
      // small 2x2 product through the predictor
      add_size(7'd2);
      add_item(CMD_LOAD, 6'd0, 6'd1, 32'd3, -32'sd7);
      add_item(CMD_LOAD, 6'd1, 6'd0, -32'sd2, 32'd11);
      add_item(CMD_LOAD, 6'd1, 6'd1, 32'h12345678, 32'h9abcdef0);
      add_item(CMD_PROD, 6'd1, 6'd0, 32'hdeadbeef, 32'h0);
      add_item(CMD_PROD, 6'd0, 6'd1, 32'h0, 32'hcafef00d);
      add_item(CMD_DIFF, 6'd1, 6'd1, 32'h0, 32'h0);
      add_known(CMD_SUM,  6'd2, 6'd1,  32'h0, 1'b1);
      add_known(CMD_PROD, 6'd1, 6'd63, 32'h0, 1'b1);
   endtask

   // One random phase: mostly legal loads and reads, some out-of-range noise
   task automatic run_phase(input logic [6:0] size_val, input int budget);
      req_word_type w;
      int           n;
      int           start;
      write_size(size_val);
      req_burst = ($urandom_range(0, 3) == 0);
      start     = items_sent;
      while (items_sent - start < budget) begin
         n         = eff_size();
         w.a_value = $urandom;
         w.b_value = $urandom;
         w.cmd     = ($urandom_range(0, 99) < 30) ? CMD_LOAD : cmd_type'($urandom_range(1, 3));
         // allow one wide product a run, each needs a full row and column loaded
         if (w.cmd == CMD_PROD && n > 16) begin
            if (wide_prod_done || $urandom_range(0, 3) != 0)
               w.cmd = CMD_SUM;
            else
               wide_prod_done = 1'b1;
         end
         if (n < MAX_DIM && (n == 0 || $urandom_range(0, 9) == 0)) begin
            if ($urandom_range(0, 1)) begin
               w.row_index = IDX_W'($urandom_range(n, MAX_DIM - 1));
               w.col_index = IDX_W'($urandom);
            end else begin
               w.row_index = IDX_W'($urandom);
               w.col_index = IDX_W'($urandom_range(n, MAX_DIM - 1));
            end
         end else begin
            w.row_index = IDX_W'($urandom_range(0, n - 1));
            w.col_index = IDX_W'($urandom_range(0, n - 1));
            if (w.cmd != CMD_LOAD)
               load_missing(w);
         end
         send_req(w, 1'b0, '0);
         if ($urandom_range(0, 24) == 0)
            wait_idle(0);
         if ($urandom_range(0, 31) == 0)
            req_burst = ~req_burst;
      end
   endtask

   initial begin
      logic [6:0] phase_sizes [14];
      phase_sizes = '{7'd4, 7'd1, 7'd0, 7'd3, 7'd64, 7'd6, 7'd2,
                      7'd127, 7'd8, 7'd5, 7'd65, 7'd3, 7'd16, 7'd2};
      build_script();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed rows
      foreach (script_rows[i]) begin
         if (script_rows[i].kind == ROW_SIZE)
            write_size(script_rows[i].size_val);
         else
            send_req(script_rows[i].word, script_rows[i].typed, script_rows[i].result);
      end

      // Random phases across sizes
      foreach (phase_sizes[i])
         run_phase(phase_sizes[i], PHASE_BUDGET);

      // Drain and let any stray word show up
      wait_idle(MAX_DIM + 16);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
